@@ rtl/core/rpn_pkg.sv @@
// Package with shared types and constants of the RPN stack calculator.
`default_nettype none

package rpn_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned DataW         = 32;
  localparam int unsigned DepthW        = 5;

  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DIV0 = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_OP   = 1'b1
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_in;
    logic ld_right;
    logic ld_left;
    logic exec;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic commit;
  } rpn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_op;
    op_e  opcode;
    logic div_direct;
    logic div_last;
    logic out_busy;
  } rpn_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rpn_in_if.sv @@
// Handshake channel carrying one calculator input item.
`default_nettype none

interface rpn_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] operand_value;
  logic        [1:0]  operator_code;

  modport source (output valid, mode, operand_value, operator_code, input ready);
  modport sink   (input valid, mode, operand_value, operator_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rpn_out_if.sv @@
// Handshake channel carrying one calculator result item.
`default_nettype none

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic        [4:0]  stack_depth;
  logic        [1:0]  status;

  modport source (output valid, top_value, stack_depth, status, input ready);
  modport sink   (input valid, top_value, stack_depth, status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rpn_stack_calculator.sv @@
// Postfix calculator over a bounded stack of signed Q16.16 values.
//
// Items arrive on req_i (valid/ready): mode 0 pushes operand_value, mode 1
// pops the right and then the left operand (zero when missing), applies
// operator_code and pushes the result. Each transaction yields one result on
// rsp_o with the new top of stack, the depth and a status code.
// Items are processed one at a time. After acceptance a push passes S_LOAD
// and S_DONE; an operator passes S_LOAD, S_FETCH and S_EXEC, then S_MUL for
// multiply or S_DIV and S_DFIN for a divide that runs the divider, and then
// S_DONE, whose commit registers the result. A divide skips the divider when
// the divisor is zero or the quotient needs more than 32 bits. The divider is
// a restoring unit that produces one quotient bit per cycle; every operator
// takes its left operand from the stack memory's registered read. req_i.ready
// rises at the edge that registers the result, ready for the next item.
// A result waiting on a stalled receiver does not block acceptance of the
// next transaction; only the commit of that next result waits for the
// output register to drain.
// Reset empties the stack and clears the output valid flag; the stack memory
// itself is not cleared, since only written entries are ever used.
`default_nettype none

module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpn_in_if.sink    req_i,
  rpn_out_if.source rsp_o
);

  rpn_cmd_t  cmd;
  rpn_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (req_i.mode),
    .operand_i    (req_i.operand_value),
    .opcode_i     (req_i.operator_code),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_top_o    (rsp_o.top_value),
    .out_depth_o  (rsp_o.stack_depth),
    .out_status_o (rsp_o.status)
  );

endmodule

`default_nettype wire

@@ rtl/core/rpn_ctrl.sv @@
// Controller state machine that sequences one calculator transaction.
`default_nettype none

module rpn_ctrl
  import rpn_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire rpn_stat_t stat_i,
  output rpn_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DFIN  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat_i.is_op) begin
          cmd_o.ld_right = 1'b1;
          state_d        = S_FETCH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FETCH: begin
        cmd_o.ld_left = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (stat_i.opcode)
          OP_MUL:  state_d = S_MUL;
          OP_DIV:  state_d = stat_i.div_direct ? S_DONE : S_DIV;
          default: state_d = S_DONE;
        endcase
      end
      S_MUL: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rpn_dp.sv @@
// Datapath: operand stack, arithmetic units, serial divider and output register.
`default_nettype none

module rpn_dp
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rpn_cmd_t           cmd_i,
  output rpn_stat_t               stat_o,
  input  wire logic               mode_i,
  input  wire logic signed [31:0] operand_i,
  input  wire logic        [1:0]  opcode_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [31:0]      out_top_o,
  output logic        [4:0]       out_depth_o,
  output logic        [1:0]       out_status_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CntTwo  = CW'(2);

  // Latched input item.
  logic               mode_q;
  logic signed [31:0] operand_q;
  op_e                opcode_q;

  // Stack storage.
  logic        [31:0] mem [STACK_DEPTH];
  logic        [31:0] rd_data_q;
  logic      [CW-1:0] cnt_q;
  logic signed [31:0] top_q;
  logic      [AW-1:0] base_addr;
  logic      [AW-1:0] wr_addr;
  logic      [CW-1:0] cnt_new;
  logic               cnt_ge2;

  // Operands and result.
  logic signed [31:0] right_q, left_q;
  logic signed [31:0] res_q;
  status_e            rstat_q;
  logic signed [63:0] prod_q;

  // Serial divider.
  logic        [31:0] rem_q, quo_q, dvs_q;
  logic               neg_q;
  logic         [4:0] step_q;
  logic        [31:0] abs_l, abs_r;
  logic        [32:0] trial, trial_sub;
  logic               q_bit;
  logic               div_ovf;

  // Add and subtract.
  logic        [32:0] sum_add, sum_sub;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_top_q;
  logic      [CW-1:0] out_cnt_q;
  status_e            out_status_q;

  assign cnt_ge2   = (cnt_q >= CntTwo);
  // After popping two operands the result lands at this address.
  assign base_addr = cnt_ge2 ? AW'(cnt_q - CntTwo) : '0;
  assign cnt_new   = CW'(base_addr) + CW'(1);
  assign wr_addr   = (mode_q == MODE_PUSH) ? AW'(cnt_q) : base_addr;

  assign abs_l   = left_q[31]  ? (~left_q  + 32'd1) : left_q;
  assign abs_r   = right_q[31] ? (~right_q + 32'd1) : right_q;
  // The quotient needs more than 32 magnitude bits exactly when this holds.
  assign div_ovf = ({16'd0, abs_l} >= {abs_r, 16'd0});

  assign sum_add = {left_q[31], left_q} + {right_q[31], right_q};
  assign sum_sub = {left_q[31], left_q} - {right_q[31], right_q};

  assign trial     = {rem_q, quo_q[31]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign q_bit     = ~trial_sub[32];

  assign stat_o.is_op      = (mode_q == MODE_OP);
  assign stat_o.opcode     = opcode_q;
  assign stat_o.div_direct = (right_q == 32'sd0) || div_ovf;
  assign stat_o.div_last   = (step_q == 5'd31);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      mode_q    <= mode_i;
      operand_q <= operand_i;
      opcode_q  <= op_e'(opcode_i);
    end
    rd_data_q <= mem[base_addr];
    if (cmd_i.commit && !(mode_q == MODE_PUSH && cnt_q >= CntFull)) begin
      mem[wr_addr] <= (mode_q == MODE_PUSH) ? operand_q : res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_right) begin
      right_q <= (cnt_q != '0) ? top_q : 32'sd0;
    end
    if (cmd_i.ld_left) begin
      left_q <= cnt_ge2 ? rd_data_q : 32'sd0;
    end
    if (cmd_i.exec) begin
      case (opcode_q)
        OP_ADD: begin
          if (sum_add[32] != sum_add[31]) begin
            res_q   <= sum_add[32] ? QMin : QMax;
            rstat_q <= ST_SAT;
          end else begin
            res_q   <= sum_add[31:0];
            rstat_q <= ST_OK;
          end
        end
        OP_SUB: begin
          if (sum_sub[32] != sum_sub[31]) begin
            res_q   <= sum_sub[32] ? QMin : QMax;
            rstat_q <= ST_SAT;
          end else begin
            res_q   <= sum_sub[31:0];
            rstat_q <= ST_OK;
          end
        end
        OP_MUL: begin
          prod_q <= left_q * right_q;
        end
        default: begin
          neg_q  <= left_q[31] ^ right_q[31];
          dvs_q  <= abs_r;
          rem_q  <= {16'd0, abs_l[31:16]};
          quo_q  <= {abs_l[15:0], 16'd0};
          step_q <= 5'd0;
          if (right_q == 32'sd0) begin
            res_q   <= left_q[31] ? QMin : QMax;
            rstat_q <= ST_DIV0;
          end else if (div_ovf) begin
            res_q   <= (left_q[31] ^ right_q[31]) ? QMin : QMax;
            rstat_q <= ST_SAT;
          end
        end
      endcase
    end
    if (cmd_i.mul_fin) begin
      // Arithmetic shift of the product rounds toward minus infinity.
      if ((&prod_q[63:47]) || !(|prod_q[63:47])) begin
        res_q   <= prod_q[47:16];
        rstat_q <= ST_OK;
      end else begin
        res_q   <= prod_q[63] ? QMin : QMax;
        rstat_q <= ST_SAT;
      end
    end
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? trial_sub[31:0] : trial[31:0];
      quo_q  <= {quo_q[30:0], q_bit};
      step_q <= step_q + 5'd1;
    end
    if (cmd_i.div_fin) begin
      if (neg_q) begin
        if (quo_q > 32'h8000_0000) begin
          res_q   <= QMin;
          rstat_q <= ST_SAT;
        end else begin
          res_q   <= ~quo_q + 32'd1;
          rstat_q <= ST_OK;
        end
      end else if (quo_q[31]) begin
        res_q   <= QMax;
        rstat_q <= ST_SAT;
      end else begin
        res_q   <= quo_q;
        rstat_q <= ST_OK;
      end
    end
    if (cmd_i.commit) begin
      if (mode_q == MODE_PUSH) begin
        if (cnt_q >= CntFull) begin
          out_top_q    <= top_q;
          out_cnt_q    <= cnt_q;
          out_status_q <= ST_FULL;
        end else begin
          top_q        <= operand_q;
          out_top_q    <= operand_q;
          out_cnt_q    <= cnt_q + CW'(1);
          out_status_q <= ST_OK;
        end
      end else begin
        top_q        <= res_q;
        out_top_q    <= res_q;
        out_cnt_q    <= cnt_new;
        out_status_q <= rstat_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (mode_q == MODE_OP) begin
          cnt_q <= cnt_new;
        end else if (cnt_q < CntFull) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_top_o    = out_top_q;
  assign out_depth_o  = DepthW'(out_cnt_q);
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the RPN stack calculator, with a stack predictor and random stalls.
`timescale 1ns / 100ps

module tb;
  import rpn_pkg::*;

  localparam int StackN     = StackDepthDef;
  localparam int RandItems  = 650;
  localparam int CycleLimit = 400000;
  localparam int EndPause   = 60;

  localparam longint SatHi = longint'(QMax);
  localparam longint SatLo = longint'(QMin);

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    mode_e              mode;
    logic signed [31:0] operand;
    op_e                opcode;
    bit                 drain_first;
    idle_mode_e         idle;
  } calc_item_t;

  typedef struct {
    logic signed [31:0] top;
    logic [4:0]         depth;
    status_e            status;
  } calc_result_t;

  logic clk_i;
  logic rst_ni;

  rpn_in_if  req ();
  rpn_out_if rsp ();

  rpn_stack_calculator #(
    .STACK_DEPTH(StackN)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state: a shadow of the operand stack.
  logic signed [31:0] stack_mem [StackN];
  int                 stack_cnt;

  calc_item_t   items_todo [$];
  calc_result_t expected_q [$];

  int         gen_depth;
  int         queued_total;
  int         accepted_cnt;
  int         result_cnt;
  int         mismatches;
  int         cycle_cnt;
  bit         in_took;
  idle_mode_e idle_now;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at result %0d: got %h, expected %h",
             what, result_cnt, got, want);
    mismatches++;
  endtask

  function automatic longint pop_operand();
    if (stack_cnt == 0) return 0;
    stack_cnt--;
    return longint'(stack_mem[stack_cnt]);
  endfunction

  function automatic calc_result_t stack_step(calc_item_t it);
    longint       rhs;
    longint       lhs;
    longint       acc;
    bit           sat;
    status_e      st;
    calc_result_t r;
    st  = ST_OK;
    sat = 1'b0;
    acc = 0;
    if (it.mode == MODE_PUSH) begin
      if (stack_cnt >= StackN) begin
        st = ST_FULL;
      end else begin
        stack_mem[stack_cnt] = it.operand;
        stack_cnt++;
      end
    end else begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (it.opcode)
        OP_ADD: acc = lhs + rhs;
        OP_SUB: acc = lhs - rhs;
        // The arithmetic shift floors the exact product toward minus infinity.
        OP_MUL: acc = (lhs * rhs) >>> 16;
        default: begin
          if (rhs == 0) begin
            acc = (lhs < 0) ? SatLo : SatHi;
            st  = ST_DIV0;
          end else begin
            acc = (lhs * 65536) / rhs;
          end
        end
      endcase
      if (acc > SatHi) begin
        acc = SatHi;
        sat = 1'b1;
      end else if (acc < SatLo) begin
        acc = SatLo;
        sat = 1'b1;
      end
      if (st == ST_OK && sat) st = ST_SAT;
      if (stack_cnt < StackN) begin
        stack_mem[stack_cnt] = acc[31:0];
        stack_cnt++;
      end
    end
    r.top    = (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : '0;
    r.depth  = 5'(stack_cnt);
    r.status = st;
    return r;
  endfunction

  task automatic queue_item(mode_e mode, logic signed [31:0] value, op_e opcode,
                            idle_mode_e idle, bit drain_first);
    calc_item_t it;
    it.mode        = mode;
    it.operand     = value;
    it.opcode      = opcode;
    it.idle        = idle;
    it.drain_first = drain_first;
    items_todo.push_back(it);
    queued_total++;
    if (mode == MODE_PUSH) begin
      if (gen_depth < StackN) gen_depth++;
    end else begin
      gen_depth = (gen_depth <= 1) ? 1 : gen_depth - 1;
    end
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return QMax;
      1:       return QMin;
      2:       return '0;
      3:       return (int'($urandom_range(0, 16)) - 8) <<< 16;
      4:       return int'($urandom_range(0, 131071)) - 65536;
      5:       return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Request driver: presents the head of the pending list at the falling edge and drives random stalls on rsp.ready.
  always @(negedge clk_i) begin : feed_requests
    int send_pct;
    int recv_pct;
    bit hold;
    if (rst_ni) begin
      if (items_todo.size() != 0) idle_now = items_todo[0].idle;
      send_pct = (idle_now == IDLE_SEND) ? 63 : (idle_now == IDLE_BOTH) ? 9 : 0;
      recv_pct = (idle_now == IDLE_RECV) ? 63 : (idle_now == IDLE_BOTH) ? 9 : 0;
      rsp.ready <= ($urandom_range(0, 99) >= recv_pct);
      if (!req.valid || in_took) begin
        hold = 1'b1;
        if (items_todo.size() != 0) begin
          hold = (items_todo[0].drain_first && expected_q.size() != 0) ||
                 ($urandom_range(0, 99) < send_pct);
        end
        if (hold) begin
          req.valid <= 1'b0;
        end else begin
          req.valid         <= 1'b1;
          req.mode          <= items_todo[0].mode;
          req.operand_value <= items_todo[0].operand;
          req.operator_code <= items_todo[0].opcode;
          items_todo.pop_front();
        end
      end
    end
  end

  // Monitor: checks each result transaction, then predicts for each accepted item.
  always @(posedge clk_i) begin : check_results
    calc_result_t want;
    calc_item_t   seen;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("== FAIL ==");
        $finish;
      end else begin
        if (rsp.valid && rsp.ready) begin
          if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp.top_value, '0);
          end else begin
            want = expected_q.pop_front();
            if (rsp.top_value !== want.top)
              report_mismatch("top_value", rsp.top_value, want.top);
            if (rsp.stack_depth !== want.depth)
              report_mismatch("stack_depth", 32'(rsp.stack_depth), 32'(want.depth));
            if (rsp.status !== want.status)
              report_mismatch("status", 32'(rsp.status), 32'(want.status));
          end
          result_cnt++;
        end
        in_took <= req.valid && req.ready;
        if (req.valid && req.ready) begin
          seen.mode    = mode_e'(req.mode);
          seen.operand = req.operand_value;
          seen.opcode  = op_e'(req.operator_code);
          expected_q.push_back(stack_step(seen));
          accepted_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int         burst_left;
    int         per_phase;
    idle_mode_e ph;
    rst_ni            = 1'b0;
    req.valid         = 1'b0;
    req.mode          = MODE_PUSH;
    req.operand_value = '0;
    req.operator_code = OP_ADD;
    rsp.ready         = 1'b0;
    in_took           = 1'b0;
    idle_now          = IDLE_NONE;
    stack_cnt         = 0;
    gen_depth         = 0;
    queued_total      = 0;
    accepted_cnt      = 0;
    result_cnt        = 0;
    mismatches        = 0;
    cycle_cnt         = 0;
    burst_left        = 0;

    // Directed: missing operands, overflow of every operator, rounding, divide by zero.
    queue_item(MODE_OP,   $urandom, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_SUB, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMax, OP_ADD, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMax, OP_MUL, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_ADD, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMin, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMax, OP_SUB, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_SUB, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMax, OP_ADD, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_MUL, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'hFFFF_FFFF, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'h0000_0003, OP_SUB, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_MUL, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, '0, OP_ADD, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'h0001_0000, OP_MUL, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'h0000_0001, OP_ADD, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'hFFFF_FFF9, OP_SUB, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'h0002_0000, OP_MUL, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, 32'h1234_5678, OP_ADD, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_DIV, IDLE_NONE, 1'b0);
    // Fill the stack, then push twice onto the full stack and reduce it once.
    while (gen_depth < StackN) queue_item(MODE_PUSH, pick_operand(), OP_SUB, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMin, OP_MUL, IDLE_NONE, 1'b0);
    queue_item(MODE_PUSH, QMax, OP_DIV, IDLE_NONE, 1'b0);
    queue_item(MODE_OP,   $urandom, OP_ADD, IDLE_NONE, 1'b0);

    // Random part in four idling phases; each phase opens on a drained block.
    per_phase = RandItems / 4;
    for (int p = 0; p < 4; p++) begin
      ph = idle_mode_e'(p);
      for (int n = 0; n < per_phase; n++) begin
        if (burst_left == 0 && $urandom_range(0, 99) < 4)
          burst_left = StackN - gen_depth + int'($urandom_range(1, 2));
        if (burst_left > 0) begin
          burst_left--;
          queue_item(MODE_PUSH, pick_operand(), op_e'($urandom_range(0, 3)), ph, n == 0);
        end else if ($urandom_range(0, 99) < 55) begin
          queue_item(MODE_PUSH, pick_operand(), op_e'($urandom_range(0, 3)), ph, n == 0);
        end else begin
          queue_item(MODE_OP, $urandom, op_e'($urandom_range(0, 3)), ph, n == 0);
        end
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cnt < queued_total || expected_q.size() != 0) @(negedge clk_i);
    // The slowest operation is a full divide through the serial divider.
    repeat (EndPause) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ rpn_stack_calculator.f @@
rtl/core/rpn_pkg.sv
rtl/core/rpn_in_if.sv
rtl/core/rpn_out_if.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_dp.sv
rtl/core/rpn_stack_calculator.sv
verif/tb.sv
